@@ sv/scds_pkg.sv @@
// ----------------------------------------------------------------------------
// scds_pkg
// shared types and constants of the serial clock prescaler search
// ----------------------------------------------------------------------------
`default_nettype none

package scds_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned DVS_W  = DATA_W + 1;  // divisor may be target + 1
  localparam int unsigned STEP_W = 4;

  localparam logic [7:0]        PRESCALE_MIN  = 8'd2;
  localparam logic [7:0]        PRESCALE_MAX  = 8'd254;
  localparam logic [7:0]        PRESCALE_STEP = 8'd2;
  localparam logic [DATA_W-1:0] SRC_CLK_RESET = 32'd204000000;

  // radix-4 steps minus one: full 32-bit quotient, or 8-bit divider quotient
  localparam logic [STEP_W-1:0] STEPS_FULL  = 4'd15;
  localparam logic [STEP_W-1:0] STEPS_SHORT = 4'd3;

  typedef struct packed {
    logic              start;
    logic [DVS_W-1:0]  rem_init;
    logic [DATA_W-1:0] dividend;
    logic [DVS_W-1:0]  divisor;
    logic [STEP_W-1:0] last_step;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              busy;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ sv/scds_divider.sv @@
// ----------------------------------------------------------------------------
// scds_divider
// radix-4 restoring divider, one quotient digit of two bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module scds_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scds_pkg::div_req_t req_i,
  output scds_pkg::div_rsp_t rsp_o
);

  logic [scds_pkg::DVS_W-1:0]  rem_q;
  logic [scds_pkg::DATA_W-1:0] num_q;
  logic [scds_pkg::DATA_W-1:0] quo_q;
  logic [scds_pkg::DVS_W-1:0]  dvs_q;
  logic [scds_pkg::DVS_W+1:0]  dvs3_q;
  logic [scds_pkg::STEP_W-1:0] cnt_q;
  logic                        busy_q;
  logic                        done_q;

  logic [scds_pkg::DVS_W+1:0]  r4;
  logic [scds_pkg::DVS_W+1:0]  d1;
  logic [scds_pkg::DVS_W+1:0]  d2;
  logic [scds_pkg::DVS_W+1:0]  rnew;
  logic [1:0]                  digit;
  logic [scds_pkg::DVS_W+1:0]  dvs3_d;

  always_comb begin
    r4     = {rem_q, num_q[scds_pkg::DATA_W-1 -: 2]};
    d1     = {2'b00, dvs_q};
    d2     = {1'b0, dvs_q, 1'b0};
    dvs3_d = {2'b00, req_i.divisor} + {1'b0, req_i.divisor, 1'b0};
    if (r4 >= dvs3_q) begin
      digit = 2'd3;
      rnew  = r4 - dvs3_q;
    end else if (r4 >= d2) begin
      digit = 2'd2;
      rnew  = r4 - d2;
    end else if (r4 >= d1) begin
      digit = 2'd1;
      rnew  = r4 - d1;
    end else begin
      digit = 2'd0;
      rnew  = r4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      num_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      dvs3_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rem_q  <= req_i.rem_init;
        num_q  <= req_i.dividend;
        quo_q  <= '0;
        dvs_q  <= req_i.divisor;
        dvs3_q <= dvs3_d;
        cnt_q  <= req_i.last_step;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        // remainder stays below the divisor, so the top bits are zero
        rem_q <= rnew[scds_pkg::DVS_W-1:0];
        num_q <= {num_q[scds_pkg::DATA_W-3:0], 2'b00};
        quo_q <= {quo_q[scds_pkg::DATA_W-3:0], digit};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.busy     = busy_q;
  assign rsp_o.quotient = quo_q;

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still stepping");

  a_busy_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(req_i.start))
    else $error("divider became busy without a start");

endmodule

`default_nettype wire

@@ sv/spi_clock_divisor_search_core.sv @@
// ----------------------------------------------------------------------------
// spi_clock_divisor_search_core
// finds the even prescaler and rate divider giving the highest serial clock
// rate at or below a requested rate, for the configured source clock
// a prescaler whose divider range cannot reach the request takes one division, others three
// the single radix-4 divider computes q = src / p, d = q / (target + 1), q / (d + 1)
// start is taken only in the idle state; busy falls as done rises
// done pulses one cycle with the result; the receiver cannot stall
// asynchronous active-low reset; source clock register resets to 204 MHz
// ----------------------------------------------------------------------------
`default_nettype none

module spi_clock_divisor_search_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start,
  input  logic [31:0] target_hz_i,
  output logic        busy,
  output logic        done_o,
  output logic [7:0]  prescale_o,
  output logic [7:0]  rate_divider_o,
  output logic [30:0] achieved_hz_o,
  output logic        found_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_QUO,
    S_DVD,
    S_RATE
  } state_e;

  state_e                      state_q;
  logic [scds_pkg::DATA_W-1:0] src_q;
  logic [scds_pkg::DVS_W-1:0]  tp1_q;
  logic [7:0]                  p_q;
  logic [scds_pkg::DATA_W-1:0] q_q;
  logic [7:0]                  d_q;
  logic [7:0]                  best_p_q;
  logic [7:0]                  best_d_q;
  logic [30:0]                 best_rate_q;
  scds_pkg::div_req_t          req_q;
  scds_pkg::div_rsp_t          rsp;

  logic [30:0] rate_w;
  logic        take_w;
  logic        ovf_w;
  logic        next_p_w;
  logic [7:0]  p_nxt_w;
  logic [7:0]  best_p_d;
  logic [7:0]  best_d_d;
  logic [30:0] best_rate_d;

  scds_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_q),
    .rsp_o  (rsp)
  );

  always_comb begin
    // quotients here never exceed src / 2, so bit 31 is always clear
    rate_w   = rsp.quotient[30:0];
    take_w   = (state_q == S_RATE) && rsp.done && (rate_w != '0) &&
               (rate_w > best_rate_q);
    // divider quotient would pass 255: no divider fits this prescaler
    ovf_w    = {9'd0, rsp.quotient[scds_pkg::DATA_W-1:8]} >= tp1_q;
    next_p_w = rsp.done && (((state_q == S_QUO) && ovf_w) || (state_q == S_RATE));
    p_nxt_w  = p_q + scds_pkg::PRESCALE_STEP;
    best_p_d    = take_w ? p_q    : best_p_q;
    best_d_d    = take_w ? d_q    : best_d_q;
    best_rate_d = take_w ? rate_w : best_rate_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      src_q          <= scds_pkg::SRC_CLK_RESET;
      tp1_q          <= '0;
      p_q            <= scds_pkg::PRESCALE_MIN;
      q_q            <= '0;
      d_q            <= '0;
      best_p_q       <= scds_pkg::PRESCALE_MIN;
      best_d_q       <= '0;
      best_rate_q    <= '0;
      req_q          <= '0;
      done_o         <= 1'b0;
      prescale_o     <= scds_pkg::PRESCALE_MIN;
      rate_divider_o <= '0;
      achieved_hz_o  <= '0;
      found_o        <= 1'b0;
    end else begin
      req_q.start <= 1'b0;
      done_o      <= 1'b0;
      if (cfg_we_i) begin
        src_q <= cfg_wdata_i;
      end
      best_p_q    <= best_p_d;
      best_d_q    <= best_d_d;
      best_rate_q <= best_rate_d;

      case (state_q)
        S_IDLE: begin
          if (start) begin
            tp1_q       <= {1'b0, target_hz_i} + 33'd1;
            p_q         <= scds_pkg::PRESCALE_MIN;
            best_p_q    <= scds_pkg::PRESCALE_MIN;
            best_d_q    <= '0;
            best_rate_q <= '0;
            req_q.start     <= 1'b1;
            req_q.rem_init  <= '0;
            req_q.dividend  <= src_q;
            req_q.divisor   <= {25'd0, scds_pkg::PRESCALE_MIN};
            req_q.last_step <= scds_pkg::STEPS_FULL;
            state_q <= S_QUO;
          end
        end
        S_QUO: begin
          if (rsp.done) begin
            q_q <= rsp.quotient;
            if (!ovf_w) begin
              // top 24 bits already below target + 1: finish the low byte
              req_q.start     <= 1'b1;
              req_q.rem_init  <= {9'd0, rsp.quotient[scds_pkg::DATA_W-1:8]};
              req_q.dividend  <= {rsp.quotient[7:0], 24'd0};
              req_q.divisor   <= tp1_q;
              req_q.last_step <= scds_pkg::STEPS_SHORT;
              state_q <= S_DVD;
            end
          end
        end
        S_DVD: begin
          if (rsp.done) begin
            d_q             <= rsp.quotient[7:0];
            req_q.start     <= 1'b1;
            req_q.rem_init  <= '0;
            req_q.dividend  <= q_q;
            req_q.divisor   <= {24'd0, {1'b0, rsp.quotient[7:0]} + 9'd1};
            req_q.last_step <= scds_pkg::STEPS_FULL;
            state_q <= S_RATE;
          end
        end
        S_RATE: begin
          // update of the best pair is carried by best_*_d
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      if (next_p_w) begin
        if (p_q == scds_pkg::PRESCALE_MAX) begin
          done_o         <= 1'b1;
          prescale_o     <= best_p_d;
          rate_divider_o <= best_d_d;
          achieved_hz_o  <= best_rate_d;
          found_o        <= (best_rate_d != '0);
          state_q        <= S_IDLE;
        end else begin
          p_q             <= p_nxt_w;
          req_q.start     <= 1'b1;
          req_q.rem_init  <= '0;
          req_q.dividend  <= src_q;
          req_q.divisor   <= {25'd0, p_nxt_w};
          req_q.last_step <= scds_pkg::STEPS_FULL;
          state_q         <= S_QUO;
        end
      end
    end
  end

  assign busy = (state_q != S_IDLE);

  a_done_from_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result issued without a search in progress");

  a_none_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |->
      (prescale_o == scds_pkg::PRESCALE_MIN) && (rate_divider_o == '0) &&
      (achieved_hz_o == '0))
    else $error("nothing-fits result is not the default pair");

  a_fits_target : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> ({2'b00, achieved_hz_o} < tp1_q) && (achieved_hz_o != '0))
    else $error("chosen rate exceeds the request");

  a_even_prescale : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !prescale_o[0])
    else $error("odd prescaler reported");

  a_div_owned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.done || rsp.busy) |-> busy)
    else $error("divider active while search is idle");

endmodule

`default_nettype wire
